// ===== rtl/epso_pkg.sv =====
package epso_pkg;

   // defaults for the top-level parameters
   localparam int PHASE_BITS_DEF  = 32;
   localparam int SINE_DEPTH_DEF  = 1024;
   localparam int EXP_DEPTH_DEF   = 256;
   localparam int PHASE_COUNT_DEF = 8;

   // fixed field widths
   localparam int KNOB_W   = 15;
   localparam int CV_W     = 17;
   localparam int SR_W     = 18;
   localparam int WAVE_W   = 16;
   localparam int WAVE_NUM = 8;
   localparam int LQ_W     = 32;   // log2 frequency, Q24, signed
   localparam int FRAC_W   = 24;
   localparam int MANT_W   = 32;   // mantissa, Q30
   localparam int DVD_W    = MANT_W + FRAC_W;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;

   localparam logic signed [24:0] LOG2_10_DIV5 = 25'sd11146541;
   localparam logic signed [31:0] LOG2_C4      = 32'sd134743897;
   localparam logic signed [17:0] PITCH_MAX    = 18'sd16384;
   localparam logic signed [17:0] PITCH_MIN    = -18'sd16384;
   localparam logic [SR_W-1:0]    SR_RESET     = 18'd44100;

   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
   localparam logic [63:0] LN2_Q30     = 64'd744261118;

   typedef logic [1:0] reg_idx_type;
   localparam reg_idx_type REG_RANGE  = 2'd0;
   localparam reg_idx_type REG_OFFSET = 2'd1;
   localparam reg_idx_type REG_RATE   = 2'd2;

   typedef struct packed {
      logic                     range_mode;
      logic signed [KNOB_W-1:0] knob;
      logic [SR_W-1:0]          sample_rate;
   } cfg_type;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [SR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DVD_W-1:0] quotient;
   } div_rsp_type;

   // 2^x in Q30, x given in Q30 as a fraction of an octave
   function automatic logic [MANT_W-1:0] exp_entry(input logic [63:0] x);
      logic [63:0] y;
      logic [63:0] t;
      begin
         y = (x * LN2_Q30) >> 30;
         t = Q30_ONE;
         t = Q30_ONE + ((y * t) >> 30) / 12;
         t = Q30_ONE + ((y * t) >> 30) / 11;
         t = Q30_ONE + ((y * t) >> 30) / 10;
         t = Q30_ONE + ((y * t) >> 30) / 9;
         t = Q30_ONE + ((y * t) >> 30) / 8;
         t = Q30_ONE + ((y * t) >> 30) / 7;
         t = Q30_ONE + ((y * t) >> 30) / 6;
         t = Q30_ONE + ((y * t) >> 30) / 5;
         t = Q30_ONE + ((y * t) >> 30) / 4;
         t = Q30_ONE + ((y * t) >> 30) / 3;
         t = Q30_ONE + ((y * t) >> 30) / 2;
         t = Q30_ONE + ((y * t) >> 30) / 1;
         return t[MANT_W-1:0];
      end
   endfunction

   // round(32767*sin(2*pi*u/2^32)), quarter-wave series
   function automatic logic signed [WAVE_W-1:0] sine_entry(input logic [63:0] u);
      logic [1:0]  quad;
      logic [63:0] r;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] a;
      begin
         quad = u[31:30];
         r    = {34'd0, u[29:0]};
         if (quad[0]) begin
            r = Q30_ONE - r;
         end
         x  = (r * PI_HALF_Q30) >> 30;
         x2 = (x * x) >> 30;
         t  = Q30_ONE;
         t  = Q30_ONE - ((x2 * t) >> 30) / 110;
         t  = Q30_ONE - ((x2 * t) >> 30) / 72;
         t  = Q30_ONE - ((x2 * t) >> 30) / 42;
         t  = Q30_ONE - ((x2 * t) >> 30) / 20;
         t  = Q30_ONE - ((x2 * t) >> 30) / 6;
         s  = (x * t) >> 30;
         a  = (s * 64'd32767 + 64'd536870912) >> 30;
         if (a > 64'd32767) begin
            a = 64'd32767;
         end
         return quad[1] ? -$signed(a[WAVE_W-1:0]) : $signed(a[WAVE_W-1:0]);
      end
   endfunction

endpackage

// ===== rtl/eight_phase_exp_sine_oscillator_core.sv =====
// Path from an accepted request to its result: queue, exponent lookup,
//   56-step divide, eight sine reads through one table.
// The back end takes one request at a time, bounded by the one-bit-per-cycle divider
//   and the single shared sine table; the front queues up to two more requests.
// Reset (synchronous, active high): phase cleared, registers to defaults,
//   queue and result emptied.
module eight_phase_exp_sine_oscillator_core #(
   parameter int PHASE_BITS       = epso_pkg::PHASE_BITS_DEF,
   parameter int SINE_TABLE_DEPTH = epso_pkg::SINE_DEPTH_DEF,
   parameter int EXP_TABLE_DEPTH  = epso_pkg::EXP_DEPTH_DEF,
   parameter int PHASE_COUNT      = epso_pkg::PHASE_COUNT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [epso_pkg::CV_W-1:0]     req_cv_level,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [epso_pkg::WAVE_W-1:0]   rsp_wave_0,
   output logic signed [epso_pkg::WAVE_W-1:0]   rsp_wave_45,
   output logic signed [epso_pkg::WAVE_W-1:0]   rsp_wave_90,
   output logic signed [epso_pkg::WAVE_W-1:0]   rsp_wave_135,
   output logic signed [epso_pkg::WAVE_W-1:0]   rsp_wave_180,
   output logic signed [epso_pkg::WAVE_W-1:0]   rsp_wave_225,
   output logic signed [epso_pkg::WAVE_W-1:0]   rsp_wave_270,
   output logic signed [epso_pkg::WAVE_W-1:0]   rsp_wave_315,
   output logic                                 rsp_gate_light,
   // register port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [epso_pkg::CSR_AW-1:0]          csr_paddr,
   input  logic [epso_pkg::CSR_DW-1:0]          csr_pwdata,
   output logic [epso_pkg::CSR_DW-1:0]          csr_prdata,
   output logic                                 csr_pready
);
   import epso_pkg::*;

   // ---- registers: 0 range mode, 1 knob offset, 2 sample rate ----
   logic                     range_ff;
   logic signed [KNOB_W-1:0] knob_ff;
   logic [SR_W-1:0]          rate_ff;
   logic                     csr_wr;
   reg_idx_type              csr_idx;
   cfg_type                  cfg;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff <= 1'b0;
         knob_ff  <= '0;
         rate_ff  <= SR_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_RANGE:  range_ff <= csr_pwdata[0];
            REG_OFFSET: knob_ff  <= csr_pwdata[KNOB_W-1:0];
            REG_RATE:   rate_ff  <= csr_pwdata[SR_W-1:0];
            default:    ;   // unmapped, write dropped
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_RANGE:  csr_prdata = {31'd0, range_ff};
         REG_OFFSET: csr_prdata = {{(CSR_DW-KNOB_W){1'b0}}, knob_ff};
         REG_RATE:   csr_prdata = {{(CSR_DW-SR_W){1'b0}}, rate_ff};
         default:    csr_prdata = '0;
      endcase
   end

   assign cfg.range_mode  = range_ff;
   assign cfg.knob        = knob_ff;
   assign cfg.sample_rate = rate_ff;

   // ---- front: log2 frequency per request, into a two-entry queue ----
   logic                   q_full;
   logic                   q_push;
   logic signed [LQ_W-1:0] q_lq;
   logic                   q_pop;
   logic                   q_valid;
   logic [LQ_W-1:0]        q_data;

   epso_front u_front (
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_cv_level (req_cv_level),
      .cfg          (cfg),
      .q_full       (q_full),
      .push         (q_push),
      .lq           (q_lq)
   );

   epso_queue #(
      .WIDTH (LQ_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_lq),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_data)
   );

   // ---- back: exponent, divide by rate, accumulate, eight sine reads ----
   div_req_type                     div_req;
   div_rsp_type                     div_rsp;
   logic [WAVE_NUM-1:0][WAVE_W-1:0] waves;

   epso_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   epso_back #(
      .PHASE_BITS       (PHASE_BITS),
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
      .EXP_TABLE_DEPTH  (EXP_TABLE_DEPTH),
      .PHASE_COUNT      (PHASE_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_valid (q_valid),
      .pop_data  (q_data),
      .pop       (q_pop),
      .div_req   (div_req),
      .div_rsp   (div_rsp),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_wave  (waves),
      .rsp_gate  (rsp_gate_light)
   );

   assign rsp_wave_0   = waves[0];
   assign rsp_wave_45  = waves[1];
   assign rsp_wave_90  = waves[2];
   assign rsp_wave_135 = waves[3];
   assign rsp_wave_180 = waves[4];
   assign rsp_wave_225 = waves[5];
   assign rsp_wave_270 = waves[6];
   assign rsp_wave_315 = waves[7];

   // ---- checks ----
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("request pushed into full queue");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider restarted while busy");

   a_gate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_gate_light == (rsp_wave_0 > 16'sd0)))
      else $error("light flag disagrees with zero-degree sine");

endmodule

// ===== rtl/epso_front.sv =====
module epso_front (
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [epso_pkg::CV_W-1:0] req_cv_level,
   input  epso_pkg::cfg_type                cfg,
   input  logic                             q_full,
   output logic                             push,
   output logic signed [epso_pkg::LQ_W-1:0] lq
);
   import epso_pkg::*;

   logic signed [18:0] knob19;
   logic signed [18:0] cv19;
   logic signed [18:0] sum19;
   logic signed [43:0] slow_prod;
   logic signed [17:0] pitch;
   logic signed [17:0] pitch_cl;
   logic signed [LQ_W-1:0] lq_slow;
   logic signed [LQ_W-1:0] lq_audio;

   assign req_ready = !q_full;
   assign push      = req_valid && !q_full;

   always_comb begin
      // slow mode: log2 f = (5*knob + cv) * log2(10)/5
      knob19    = {{4{cfg.knob[KNOB_W-1]}}, cfg.knob};
      cv19      = {{2{req_cv_level[CV_W-1]}}, req_cv_level};
      sum19     = (knob19 <<< 2) + knob19 + cv19;
      slow_prod = 44'(sum19) * 44'(LOG2_10_DIV5);
      lq_slow   = slow_prod[43:12];
      // audio mode: octaves around middle C, clamped to four
      pitch     = {{3{cfg.knob[KNOB_W-1]}}, cfg.knob} + {req_cv_level[CV_W-1], req_cv_level};
      pitch_cl  = pitch;
      if (pitch > PITCH_MAX) begin
         pitch_cl = PITCH_MAX;
      end else if (pitch < PITCH_MIN) begin
         pitch_cl = PITCH_MIN;
      end
      lq_audio  = ({{14{pitch_cl[17]}}, pitch_cl} <<< 12) + LOG2_C4;
      lq        = cfg.range_mode ? lq_audio : lq_slow;
   end

endmodule

// ===== rtl/epso_queue.sv =====
module epso_queue #(
   parameter int WIDTH = epso_pkg::LQ_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);
   import epso_pkg::*;

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ff;
   logic             rd_ff;
   logic [1:0]       cnt_ff;
   logic [1:0]       cnt_in;

   assign full      = (cnt_ff == 2'd2);
   assign pop_valid = (cnt_ff != 2'd0);
   assign pop_data  = mem_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !(pop && pop_valid)) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!push && pop && pop_valid) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ff <= !wr_ff;
         end
         if (pop && pop_valid) begin
            rd_ff <= !rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/epso_div.sv =====
module epso_div (
   input  logic                  clock,
   input  logic                  reset,
   input  epso_pkg::div_req_type req,
   output epso_pkg::div_rsp_type rsp
);
   import epso_pkg::*;

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] quo_ff;
   logic [SR_W-1:0]  rem_ff;
   logic [SR_W-1:0]  dvs_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [SR_W:0]    rem_sh;
   logic [SR_W+1:0]  diff;
   logic             ge;

   // one quotient bit a cycle, restoring
   assign rem_sh = {rem_ff, quo_ff[DVD_W-1]};
   assign diff   = {1'b0, rem_sh} - {2'b00, dvs_ff};
   assign ge     = !diff[SR_W+1];

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DVD_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         quo_ff <= req.dividend;
         rem_ff <= '0;
         dvs_ff <= req.divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DVD_W-2:0], ge};
         rem_ff <= ge ? diff[SR_W-1:0] : rem_sh[SR_W-1:0];
      end
   end

endmodule

// ===== rtl/epso_back.sv =====
module epso_back #(
   parameter int PHASE_BITS       = epso_pkg::PHASE_BITS_DEF,
   parameter int SINE_TABLE_DEPTH = epso_pkg::SINE_DEPTH_DEF,
   parameter int EXP_TABLE_DEPTH  = epso_pkg::EXP_DEPTH_DEF,
   parameter int PHASE_COUNT      = epso_pkg::PHASE_COUNT_DEF
) (
   input  logic                                                   clock,
   input  logic                                                   reset,
   input  epso_pkg::cfg_type                                      cfg,
   input  logic                                                   pop_valid,
   input  logic [epso_pkg::LQ_W-1:0]                              pop_data,
   output logic                                                   pop,
   output epso_pkg::div_req_type                                  div_req,
   input  epso_pkg::div_rsp_type                                  div_rsp,
   input  logic                                                   rsp_ready,
   output logic                                                   rsp_valid,
   output logic [epso_pkg::WAVE_NUM-1:0][epso_pkg::WAVE_W-1:0]    rsp_wave,
   output logic                                                   rsp_gate
);
   import epso_pkg::*;

   localparam int EIW  = $clog2(EXP_TABLE_DEPTH + 1);
   localparam int EFW  = FRAC_W + EIW;
   localparam int SKW  = $clog2(SINE_TABLE_DEPTH);
   localparam int SPW  = PHASE_BITS + $clog2(SINE_TABLE_DEPTH + 1);
   localparam int KOFF = PHASE_BITS - 54;
   localparam int WSH  = PHASE_BITS - 3;
   localparam logic [63:0] INC_MAX = 64'((65'd1 << PHASE_BITS) - 65'd1);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b00_0000_0001,
      S_IDX   = 10'b00_0000_0010,
      S_RD    = 10'b00_0000_0100,
      S_MUL   = 10'b00_0000_1000,
      S_SUM   = 10'b00_0001_0000,
      S_DIV   = 10'b00_0010_0000,
      S_SHIFT = 10'b00_0100_0000,
      S_ADDR  = 10'b00_1000_0000,
      S_LOOK  = 10'b01_0000_0000,
      S_DONE  = 10'b10_0000_0000
   } bstate_type;

   logic [MANT_W-1:0]        exp_rom [EXP_TABLE_DEPTH+1];
   logic signed [WAVE_W-1:0] sine_rom [SINE_TABLE_DEPTH];

   for (genvar g = 0; g <= EXP_TABLE_DEPTH; g++) begin : g_exp
      localparam logic [63:0] XQ = (64'(g) << 30) / EXP_TABLE_DEPTH;
      assign exp_rom[g] = exp_entry(XQ);
   end

   for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_sine
      localparam logic [63:0] UQ = ((64'(g) << 32) / SINE_TABLE_DEPTH) & 64'hFFFF_FFFF;
      assign sine_rom[g] = sine_entry(UQ);
   end

   bstate_type               state_ff;
   bstate_type               state_in;
   logic signed [7:0]        n_ff;
   logic [FRAC_W-1:0]        f_ff;
   logic [EIW-1:0]           idx_ff;
   logic [FRAC_W-1:0]        wgt_ff;
   logic [MANT_W-1:0]        e0_ff;
   logic [MANT_W-1:0]        e1_ff;
   logic [DVD_W-1:0]         prod_ff;
   logic [DVD_W-1:0]         q_ff;
   logic [PHASE_BITS-1:0]    acc_ff;
   logic [2:0]               widx_ff;
   logic [SKW-1:0]           kidx_ff;
   logic signed [WAVE_W-1:0] wave_ff [WAVE_NUM];
   logic [WAVE_NUM-1:0][WAVE_W-1:0] rsp_wave_ff;
   logic                     rsp_gate_ff;
   logic                     rsp_valid_ff;

   logic [EFW-1:0]           fi;
   logic [MANT_W-1:0]        m_sum;
   logic signed [9:0]        k;
   logic signed [9:0]        kneg;
   logic [63:0]              q64;
   logic [63:0]              shl;
   logic [63:0]              shr;
   logic                     sat_hi;
   logic [63:0]              inc64;
   logic [PHASE_BITS-1:0]    p;
   logic [SPW-1:0]           kprod;
   logic                     out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop       = (state_ff == S_IDLE) && pop_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_wave  = rsp_wave_ff;
   assign rsp_gate  = rsp_gate_ff;

   always_comb begin
      fi    = EFW'(f_ff) * EFW'(EXP_TABLE_DEPTH);
      m_sum = e0_ff + prod_ff[DVD_W-1:FRAC_W];
      // increment shift: n + PHASE_BITS - 54, saturate at full cycle
      k      = {{2{n_ff[7]}}, n_ff} + 10'(KOFF);
      kneg   = -k;
      q64    = 64'(q_ff);
      shl    = q64 << k[6:0];
      shr    = q64 >> kneg[6:0];
      sat_hi = (q64 >> (7'(PHASE_BITS) - k[6:0])) != 64'd0;
      if (!k[9]) begin
         inc64 = sat_hi ? INC_MAX : (shl & INC_MAX);
      end else if (kneg > 10'sd63) begin
         inc64 = 64'd0;
      end else begin
         inc64 = (shr > INC_MAX) ? INC_MAX : shr;
      end
      p     = acc_ff + (PHASE_BITS'(widx_ff) << WSH);
      kprod = SPW'(p) * SPW'(SINE_TABLE_DEPTH);
   end

   assign div_req.start    = (state_ff == S_SUM);
   assign div_req.dividend = {m_sum, {FRAC_W{1'b0}}};
   assign div_req.divisor  = (cfg.sample_rate == '0) ? SR_W'(1) : cfg.sample_rate;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (pop_valid) begin
                     state_in = S_IDX;
                  end
         S_IDX:   state_in = S_RD;
         S_RD:    state_in = S_MUL;
         S_MUL:   state_in = S_SUM;
         S_SUM:   state_in = S_DIV;
         S_DIV:   if (div_rsp.done) begin
                     state_in = S_SHIFT;
                  end
         S_SHIFT: state_in = S_ADDR;
         S_ADDR:  state_in = S_LOOK;
         S_LOOK:  state_in = (widx_ff == 3'd7) ? S_DONE : S_ADDR;
         S_DONE:  if (out_free) begin
                     state_in = S_IDLE;
                  end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         acc_ff       <= '0;
         widx_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_SHIFT) begin
            acc_ff  <= acc_ff + inc64[PHASE_BITS-1:0];
            widx_ff <= '0;
         end
         if (state_ff == S_LOOK) begin
            widx_ff <= widx_ff + 3'd1;
         end
         if (state_ff == S_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE:  if (pop_valid) begin
                     n_ff <= pop_data[LQ_W-1:FRAC_W];
                     f_ff <= pop_data[FRAC_W-1:0];
                  end
         S_IDX:   begin
                     idx_ff <= fi[FRAC_W +: EIW];
                     wgt_ff <= fi[FRAC_W-1:0];
                  end
         S_RD:    begin
                     e0_ff <= exp_rom[idx_ff];
                     e1_ff <= exp_rom[idx_ff + EIW'(1)];
                  end
         S_MUL:   prod_ff <= DVD_W'(e1_ff - e0_ff) * DVD_W'(wgt_ff);
         S_DIV:   if (div_rsp.done) begin
                     q_ff <= div_rsp.quotient;
                  end
         S_ADDR:  kidx_ff <= kprod[PHASE_BITS +: SKW];
         S_LOOK:  wave_ff[widx_ff] <= ({1'b0, widx_ff} < 4'(PHASE_COUNT)) ?
                                      sine_rom[kidx_ff] : '0;
         S_DONE:  if (out_free) begin
                     for (int i = 0; i < WAVE_NUM; i++) begin
                        rsp_wave_ff[i] <= wave_ff[i];
                     end
                     rsp_gate_ff <= (wave_ff[0] > 16'sd0);
                  end
         default: ;
      endcase
   end

endmodule
